// ===== sv/hbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hbm_pkg;

    localparam int NUM_CONSUMERS    = 5;
    localparam int NODE_TABLE_DEPTH = 128;
    localparam int TBL_AW           = $clog2(NODE_TABLE_DEPTH);
    localparam int CONS_IDX_W       = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COUNT_W    = 3;

    localparam logic [6:0]  STATE_DISCONNECTED = 7'd1;
    localparam logic [6:0]  STATE_UNKNOWN      = 7'd15;
    localparam logic [10:0] TX_COB_BASE        = 11'h700;

    // result kinds
    localparam logic [1:0] RK_TX      = 2'd0;
    localparam logic [1:0] RK_TIMEOUT = 2'd1;
    localparam logic [1:0] RK_CHANGE  = 2'd2;

    // input kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY0 = 3'd3;

    typedef struct packed {
        logic       kind;
        logic [6:0] frame_node_id;
        logic       frame_remote;
        logic [7:0] frame_byte0;
        logic [6:0] own_state;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [10:0] tx_cob_id;
        logic [7:0]  tx_byte;
        logic [6:0]  event_node_id;
        logic [6:0]  event_state;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [6:0]                                own_node_id;
        logic [15:0]                               producer_period_ms;
        logic [COUNT_W-1:0]                        consumer_count;
        logic [NUM_CONSUMERS-1:0][CFG_DATA_W-1:0]  consumer_entry;
    } cfg_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [TBL_AW-1:0] addr;
        logic [6:0]        wr_data;
    } tbl_req_t;

    typedef struct packed {
        logic [15:0] opa;
        logic        dec;
        logic [15:0] limit;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] res;
        logic        res_zero;
        logic        res_ge;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== sv/hbm_step_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hbm_step_alu
    import hbm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [15:0] sum;

    // one 16-bit increment or decrement, with zero and limit compare
    always_comb begin
        sum          = req.dec ? (req.opa - 16'd1) : (req.opa + 16'd1);
        rsp.res      = sum;
        rsp.res_zero = (sum == 16'd0);
        rsp.res_ge   = (sum >= req.limit);
    end

endmodule
`default_nettype wire

// ===== sv/hbm_node_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hbm_node_table
    import hbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  tbl_req_t   req,
    output logic [6:0] rd_data
);

    logic [6:0]                  mem_reg [NODE_TABLE_DEPTH];
    logic [NODE_TABLE_DEPTH-1:0] valid_reg;
    logic [6:0]                  rd_mem_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_mem_reg <= mem_reg[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    // never written entries read as unknown state
    assign rd_data = rd_valid_reg ? rd_mem_reg : STATE_UNKNOWN;

endmodule
`default_nettype wire

// ===== sv/hbm_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hbm_sequencer
    import hbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  in_word_t   s_data,
    output logic       s_ready,
    input  cfg_t       cfg,
    input  logic       slot_free,
    output logic       emit_valid,
    output out_word_t  emit_word,
    output tbl_req_t   tbl_req,
    input  logic [6:0] tbl_rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANSWER,
        ST_CMP,
        ST_REARM,
        ST_TICK_START,
        ST_TICK_WD,
        ST_TICK_PROD
    } seq_state_t;

    seq_state_t              state_reg;
    in_word_t                item_reg;
    logic [CONS_IDX_W-1:0]   idx_reg;
    logic [15:0]             wd_reg [NUM_CONSUMERS];
    logic [15:0]             prod_cnt_reg;
    logic                    toggle_reg;
    logic [NUM_CONSUMERS:0]  pend_reg;

    alu_req_t                alu_req;
    alu_rsp_t                alu_rsp;

    logic                    accept;
    logic [6:0]              new_state;
    logic                    changed;
    logic [15:0]             wd_cur;
    logic [CFG_DATA_W-1:0]   entry_cur;
    logic [7:0]              wid_cur;
    logic                    wid_in_table;
    logic                    idx_last;
    logic                    expire_now;
    logic [NUM_CONSUMERS:0]  later_mask;
    logic                    timeout_last;
    logic [NUM_CONSUMERS-1:0] expire_vec;
    logic                    prod_fire;
    logic [10:0]             own_cob;

    hbm_step_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb begin
        accept       = s_valid && s_ready;
        new_state    = item_reg.frame_byte0[6:0];
        changed      = (tbl_rd_data != new_state);
        wd_cur       = wd_reg[idx_reg];
        entry_cur    = cfg.consumer_entry[idx_reg];
        wid_cur      = entry_cur[23:16];
        wid_in_table = (32'(wid_cur) < NODE_TABLE_DEPTH);
        idx_last     = (idx_reg == CONS_IDX_W'(NUM_CONSUMERS - 1));
        own_cob      = TX_COB_BASE | {4'b0000, cfg.own_node_id};

        alu_req.opa   = (state_reg == ST_TICK_START) ? prod_cnt_reg : wd_cur;
        alu_req.dec   = (state_reg != ST_TICK_START);
        alu_req.limit = cfg.producer_period_ms;

        expire_now = (wd_cur != 16'd0) && alu_rsp.res_zero;
        prod_fire  = (cfg.producer_period_ms != 16'd0) && alu_rsp.res_ge;

        for (int i = 0; i < NUM_CONSUMERS; i++) begin
            expire_vec[i] = (wd_reg[i] == 16'd1);
            later_mask[i] = (CONS_IDX_W'(i) > idx_reg);
        end
        later_mask[NUM_CONSUMERS] = 1'b1;
        timeout_last = ~|(pend_reg & later_mask);
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        emit_valid      = 1'b0;
        emit_word       = '0;
        tbl_req.rd_en   = 1'b0;
        tbl_req.wr_en   = 1'b0;
        tbl_req.addr    = TBL_AW'(item_reg.frame_node_id);
        tbl_req.wr_data = new_state;
        case (state_reg)
            ST_IDLE: begin
                tbl_req.rd_en = accept && (s_data.kind == KIND_FRAME) && !s_data.frame_remote;
                tbl_req.addr  = TBL_AW'(s_data.frame_node_id);
            end
            ST_ANSWER: begin
                emit_valid            = slot_free;
                emit_word.result_kind = RK_TX;
                emit_word.tx_cob_id   = own_cob;
                emit_word.tx_byte     = {toggle_reg, item_reg.own_state};
                emit_word.last        = 1'b1;
            end
            ST_CMP: begin
                emit_valid              = slot_free && changed;
                emit_word.result_kind   = RK_CHANGE;
                emit_word.event_node_id = item_reg.frame_node_id;
                emit_word.event_state   = new_state;
                emit_word.last          = 1'b1;
                tbl_req.wr_en           = slot_free && changed;
            end
            ST_TICK_WD: begin
                emit_valid              = slot_free && expire_now;
                emit_word.result_kind   = RK_TIMEOUT;
                emit_word.event_node_id = wid_cur[6:0];
                emit_word.last          = timeout_last;
                tbl_req.wr_en           = slot_free && expire_now && wid_in_table;
                tbl_req.addr            = TBL_AW'(wid_cur);
                tbl_req.wr_data         = STATE_DISCONNECTED;
            end
            ST_TICK_PROD: begin
                emit_valid            = slot_free;
                emit_word.result_kind = RK_TX;
                emit_word.tx_cob_id   = own_cob;
                emit_word.tx_byte     = {1'b0, item_reg.own_state};
                emit_word.last        = 1'b1;
            end
            default: begin
                emit_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            prod_cnt_reg <= 16'd0;
            toggle_reg   <= 1'b0;
            pend_reg     <= '0;
            for (int i = 0; i < NUM_CONSUMERS; i++) begin
                wd_reg[i] <= 16'd0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    if (accept) begin
                        if (s_data.kind == KIND_TICK) begin
                            state_reg <= ST_TICK_START;
                        end else if (s_data.frame_remote) begin
                            if (s_data.frame_node_id == cfg.own_node_id) begin
                                state_reg <= ST_ANSWER;
                            end
                        end else begin
                            state_reg <= ST_CMP;
                        end
                    end
                end
                ST_ANSWER: begin
                    if (slot_free) begin
                        toggle_reg <= ~toggle_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_CMP: begin
                    if (slot_free || !changed) begin
                        idx_reg   <= '0;
                        state_reg <= (new_state != STATE_UNKNOWN) ? ST_REARM : ST_IDLE;
                    end
                end
                ST_REARM: begin
                    if ((COUNT_W'(idx_reg) < cfg.consumer_count) &&
                        ({1'b0, item_reg.frame_node_id} == wid_cur)) begin
                        wd_reg[idx_reg] <= entry_cur[15:0];
                    end
                    if (idx_last) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + CONS_IDX_W'(1);
                    end
                end
                ST_TICK_START: begin
                    pend_reg <= {prod_fire, expire_vec};
                    if ((cfg.producer_period_ms == 16'd0) || alu_rsp.res_ge) begin
                        prod_cnt_reg <= 16'd0;
                    end else begin
                        prod_cnt_reg <= alu_rsp.res;
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_TICK_WD;
                end
                ST_TICK_WD: begin
                    if (!expire_now || slot_free) begin
                        if (wd_cur != 16'd0) begin
                            wd_reg[idx_reg] <= alu_rsp.res;
                        end
                        if (idx_last) begin
                            state_reg <= pend_reg[NUM_CONSUMERS] ? ST_TICK_PROD : ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + CONS_IDX_W'(1);
                        end
                    end
                end
                ST_TICK_PROD: begin
                    if (slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/can_heartbeat_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// heartbeat producer and consumer for a CANopen-style node. each input word is either a
// received heartbeat frame or a one millisecond tick. a remote request for the own node id
// is answered with cob id 0x700 + own id and the own state, bit 7 toggling per answer. a
// data frame updates a 128-entry node state table (a change is reported) and, unless the
// new state is unknown, re-arms every consumer watchdog in use that watches that node. a
// tick counts all armed watchdogs down (timeouts reported in entry order, a node id inside
// the table marked disconnected) and then runs the producer, which sends the own state
// every period. the block works on one word at a time with a single 16-bit step unit and
// takes no new word until it is through with the last; a stalled result port holds it up.
// the last flag marks the final result of a word. configuration is a plain write port,
// to be written only while the block is idle.
module can_heartbeat_monitor
    import hbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    cfg_t       cfg_reg;
    logic       m_valid_reg;
    out_word_t  m_data_reg;

    logic       slot_free;
    logic       emit_valid;
    out_word_t  emit_word;
    tbl_req_t   tbl_req;
    logic [6:0] tbl_rd_data;

    // configuration registers, counters are never touched by a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_node_id        <= 7'd1;
            cfg_reg.producer_period_ms <= '0;
            cfg_reg.consumer_count     <= '0;
            cfg_reg.consumer_entry     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OWN_ID: begin
                    cfg_reg.own_node_id <= cfg_wdata[6:0];
                end
                REG_PERIOD: begin
                    cfg_reg.producer_period_ms <= cfg_wdata[15:0];
                end
                REG_COUNT: begin
                    // saturate to the number of entries built
                    if (cfg_wdata[COUNT_W-1:0] > COUNT_W'(NUM_CONSUMERS)) begin
                        cfg_reg.consumer_count <= COUNT_W'(NUM_CONSUMERS);
                    end else begin
                        cfg_reg.consumer_count <= cfg_wdata[COUNT_W-1:0];
                    end
                end
                default: begin
                    // consumer entries; indexes past the built entries are dropped
                    for (int i = 0; i < NUM_CONSUMERS; i++) begin
                        if (cfg_index == (REG_ENTRY0 + CFG_IDX_W'(i))) begin
                            cfg_reg.consumer_entry[i] <= cfg_wdata;
                        end
                    end
                end
            endcase
        end
    end

    // output register parts the sequencer from the result port
    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            m_data_reg <= emit_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // node state table, one access per cycle
    hbm_node_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    // control sequencer with the shared step unit and watchdog counters
    hbm_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_data      (s_data),
        .s_ready     (s_ready),
        .cfg         (cfg_reg),
        .slot_free   (slot_free),
        .emit_valid  (emit_valid),
        .emit_word   (emit_word),
        .tbl_req     (tbl_req),
        .tbl_rd_data (tbl_rd_data)
    );

    // a tick always keeps the block busy for the next cycle
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind == KIND_TICK) |=> !s_ready)
        else $error("tick word did not occupy the sequencer");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid |-> slot_free)
        else $error("result emitted into a full output register");

    // transmit results carry the own cob id
    a_tx_cob: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == RK_TX) |->
            (m_data.tx_cob_id == (TX_COB_BASE | {4'b0000, cfg_reg.own_node_id})))
        else $error("transmit cob id does not match own node id");

    // event results leave the transmit fields clear
    a_event_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind != RK_TX) |->
            (m_data.tx_cob_id == 11'd0) && (m_data.tx_byte == 8'd0))
        else $error("event result with transmit fields set");

endmodule
`default_nettype wire

// ===== tb/sv/tb_can_heartbeat_monitor.sv =====
`timescale 1ns / 1ps
module tb_can_heartbeat_monitor
    import hbm_pkg::*;
();

    // cycles to let a word with no result finish inside the block
    localparam int DRAIN_CYCLES = 16;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;

    // idling knobs, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // long result-side hold-off, counted down in its own process
    int hold_left    = 0;
    int err_count    = 0;

    // heartbeat results still owed by the block, oldest first
    out_word_t pending_hb[$];

    // local copy of the block's registers and state
    logic [6:0]            hb_own_id;
    logic [15:0]           hb_period;
    logic [COUNT_W-1:0]    hb_count;
    logic [CFG_DATA_W-1:0] hb_entry     [NUM_CONSUMERS];
    logic                  hb_toggle;
    logic [6:0]            hb_state_tbl [NODE_TABLE_DEPTH];
    logic [15:0]           hb_wdog      [NUM_CONSUMERS];
    logic [15:0]           hb_prod_cnt;

    can_heartbeat_monitor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------
    function automatic in_word_t mk_frame(logic [6:0] node, logic remote, logic [7:0] byte0,
                                          logic [6:0] own);
        in_word_t w;
        w.kind          = KIND_FRAME;
        w.frame_node_id = node;
        w.frame_remote  = remote;
        w.frame_byte0   = byte0;
        w.own_state     = own;
        return w;
    endfunction

    // a tick still carries random frame fields, the block must ignore them
    function automatic in_word_t mk_tick(logic [6:0] own);
        in_word_t w;
        w.kind          = KIND_TICK;
        w.frame_node_id = 7'($urandom);
        w.frame_remote  = 1'($urandom);
        w.frame_byte0   = 8'($urandom);
        w.own_state     = own;
        return w;
    endfunction

    function automatic out_word_t mk_result(logic [1:0] kind, logic [10:0] cob,
                                            logic [7:0] txb, logic [6:0] node,
                                            logic [6:0] st);
        out_word_t r;
        r.result_kind   = kind;
        r.tx_cob_id     = cob;
        r.tx_byte       = txb;
        r.event_node_id = node;
        r.event_state   = st;
        r.last          = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // heartbeat predictor: updates the local state for one accepted word
    // and queues the results it must cause
    // ------------------------------------------------------------------
    function automatic void predict_hb_word(in_word_t w);
        out_word_t  res[$];
        out_word_t  tmp;
        logic [7:0] wid;
        logic [6:0] st;
        int         i;
        if (w.kind == KIND_FRAME) begin
            if (w.frame_remote) begin
                // only a request for our own id is answered, toggle goes in bit 7
                if (w.frame_node_id == hb_own_id) begin
                    res.push_back(mk_result(RK_TX, TX_COB_BASE + {4'd0, hb_own_id},
                                            {hb_toggle, w.own_state}, '0, '0));
                    hb_toggle = ~hb_toggle;
                end
            end else begin
                st = w.frame_byte0[6:0];
                if (hb_state_tbl[w.frame_node_id] != st) begin
                    res.push_back(mk_result(RK_CHANGE, '0, '0, w.frame_node_id, st));
                    hb_state_tbl[w.frame_node_id] = st;
                end
                // unknown state never re-arms; entries outside the count are skipped
                if (hb_state_tbl[w.frame_node_id] != STATE_UNKNOWN) begin
                    for (i = 0; i < hb_count; i++) begin
                        if (hb_entry[i][23:16] == {1'b0, w.frame_node_id})
                            hb_wdog[i] = hb_entry[i][15:0];
                    end
                end
            end
        end else begin
            // every armed watchdog counts, in or out of the count
            for (i = 0; i < NUM_CONSUMERS; i++) begin
                if (hb_wdog[i] != 16'd0) begin
                    hb_wdog[i] = hb_wdog[i] - 16'd1;
                    if (hb_wdog[i] == 16'd0) begin
                        wid = hb_entry[i][23:16];
                        if (wid < NODE_TABLE_DEPTH)
                            hb_state_tbl[wid[6:0]] = STATE_DISCONNECTED;
                        res.push_back(mk_result(RK_TIMEOUT, '0, '0, wid[6:0], '0));
                    end
                end
            end
            if (hb_period == 16'd0) begin
                hb_prod_cnt = 16'd0;
            end else begin
                hb_prod_cnt = hb_prod_cnt + 16'd1;
                if (hb_prod_cnt >= hb_period) begin
                    hb_prod_cnt = 16'd0;
                    res.push_back(mk_result(RK_TX, TX_COB_BASE + {4'd0, hb_own_id},
                                            {1'b0, w.own_state}, '0, '0));
                end
            end
        end
        foreach (res[k]) begin
            tmp      = res[k];
            tmp.last = (k == res.size() - 1);
            pending_hb.push_back(tmp);
        end
    endfunction

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    // offer one word with a random gap in front; valid stays up after the accept
    // so back-to-back words never drop it
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_hb_word(w);
    endtask

    // drop valid, wait for every owed result, then let a silent word finish
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_hb.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write, only called with the block idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_OWN_ID: hb_own_id = val[6:0];
            REG_PERIOD: hb_period = val[15:0];
            REG_COUNT:  hb_count  = (val[2:0] > COUNT_W'(NUM_CONSUMERS)) ?
                                    COUNT_W'(NUM_CONSUMERS) : val[2:0];
            default:    if (idx >= REG_ENTRY0) hb_entry[idx - REG_ENTRY0] = val;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch, %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // result side: check each accepted word, then pick the next ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : rx_side
        out_word_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_hb.size() == 0) begin
                report_mismatch($sformatf("unexpected result word 0x%0h", m_data));
            end else begin
                want = pending_hb.pop_front();
                check_field("result_kind",   m_data.result_kind,   want.result_kind);
                check_field("tx_cob_id",     m_data.tx_cob_id,     want.tx_cob_id);
                check_field("tx_byte",       m_data.tx_byte,       want.tx_byte);
                check_field("event_node_id", m_data.event_node_id, want.event_node_id);
                check_field("event_state",   m_data.event_state,   want.event_state);
                check_field("last",          m_data.last,          want.last);
            end
        end
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    // hold-off countdown
    always @(posedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // remote requests with the reset node id: toggle bit, other ids ignored
    task automatic test_remote_answers();
        send_word(mk_frame(7'd1, 1'b1, 8'h00, 7'h7F));
        send_word(mk_frame(7'd1, 1'b1, 8'hFF, 7'h00));
        send_word(mk_frame(7'd2, 1'b1, 8'h00, 7'h05));
        // producer disabled and nothing armed: a silent tick
        send_word(mk_tick(7'h2A));
        settle_block();
    endtask

    // node id zero and 127
    task automatic test_own_id_extremes();
        cfg_write(REG_OWN_ID, 24'd0);
        send_word(mk_frame(7'd0, 1'b1, 8'h55, 7'h7F));
        settle_block();
        cfg_write(REG_OWN_ID, 24'd127);
        send_word(mk_frame(7'd127, 1'b1, 8'hAA, 7'h55));
        settle_block();
    endtask

    // state table: extreme nodes, bit 7 of the byte dropped, unknown state unchanged
    task automatic test_node_table();
        send_word(mk_frame(7'd0,   1'b0, 8'hFF, 7'h00));
        send_word(mk_frame(7'd127, 1'b0, 8'h80, 7'h7F));
        send_word(mk_frame(7'd127, 1'b0, 8'h00, 7'h11));
        send_word(mk_frame(7'd3,   1'b0, {1'b0, STATE_UNKNOWN}, 7'h22));
        settle_block();
    endtask

    // all five watchdogs expire on one tick together with a producer send,
    // then a zero timeout and an unknown state leave them disarmed
    task automatic test_consumer_watchdogs();
        int i;
        cfg_write(REG_PERIOD, 24'd1);
        cfg_write(REG_COUNT, 24'd7);        // saturates to five
        for (i = 0; i < NUM_CONSUMERS; i++)
            cfg_write(REG_ENTRY0 + CFG_IDX_W'(i), {8'(10 + i), 16'd1});
        for (i = 0; i < NUM_CONSUMERS; i++)
            send_word(mk_frame(7'(10 + i), 1'b0, 8'h05, 7'h05));
        send_word(mk_tick(7'h7F));          // six results
        settle_block();
        cfg_write(REG_ENTRY0, {8'd10, 16'd0});
        send_word(mk_frame(7'd10, 1'b0, 8'h05, 7'h01));
        send_word(mk_frame(7'd11, 1'b0, {1'b0, STATE_UNKNOWN}, 7'h02));
        send_word(mk_tick(7'h00));
        settle_block();
    endtask

    // watchdog outside the count keeps running, an id above 127 written
    // while armed times out with its low bits and leaves the table alone,
    // an id that can never match
    task automatic test_entry_corners();
        cfg_write(REG_PERIOD, 24'd0);
        cfg_write(REG_COUNT, 24'd3);
        cfg_write(REG_ENTRY0, {8'd20, 16'd2});
        cfg_write(REG_ENTRY0 + CFG_IDX_W'(2), {8'd21, 16'd2});
        cfg_write(REG_ENTRY0 + CFG_IDX_W'(4), 24'hFFFFFF);
        send_word(mk_frame(7'd20, 1'b0, 8'h04, 7'h0A));
        send_word(mk_frame(7'd21, 1'b0, 8'h04, 7'h0B));
        settle_block();
        // config writes must not reload the running counters
        cfg_write(REG_COUNT, 24'd1);
        cfg_write(REG_ENTRY0, {8'h94, 16'd9});
        send_word(mk_tick(7'h33));
        send_word(mk_tick(7'h44));
        send_word(mk_frame(7'd20, 1'b0, 8'h04, 7'h0C));
        send_word(mk_frame(7'd21, 1'b0, 8'h04, 7'h0D));
        settle_block();
    endtask

    // producer: lowered period sends at once, disabled clears the count, max period
    task automatic test_producer_period();
        cfg_write(REG_COUNT, 24'd0);
        cfg_write(REG_PERIOD, 24'd10);
        repeat (3) send_word(mk_tick(7'($urandom)));
        settle_block();
        cfg_write(REG_PERIOD, 24'd2);
        send_word(mk_tick(7'h66));
        settle_block();
        cfg_write(REG_PERIOD, 24'd0);
        send_word(mk_tick(7'h77));
        settle_block();
        cfg_write(REG_PERIOD, 24'hFFFF);
        send_word(mk_tick(7'h01));
        settle_block();
    endtask

    // result side held off for a long stretch while ticks keep coming,
    // so the block backs up into its input
    task automatic test_backpressure();
        cfg_write(REG_PERIOD, 24'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = 400;
        repeat (8) send_word(mk_tick(7'($urandom)));
        settle_block();
    endtask

    // random traffic: mostly frames from a small pool of watched nodes and
    // ticks so watchdogs arm and expire, plus remote requests and noise
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_words);
        int         i;
        int         pick;
        logic [7:0] wid;
        logic [7:0] b;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        settle_block();
        cfg_write(REG_OWN_ID, 24'($urandom_range(127)));
        cfg_write(REG_PERIOD, ($urandom_range(4) == 0) ? 24'd0 : 24'($urandom_range(1, 6)));
        cfg_write(REG_COUNT, 24'($urandom_range(7)));
        for (i = 0; i < NUM_CONSUMERS; i++) begin
            wid = ($urandom_range(7) == 0) ? 8'($urandom_range(128, 255))
                                           : 8'($urandom_range(1, 6));
            cfg_write(REG_ENTRY0 + CFG_IDX_W'(i), {wid, 16'($urandom_range(8))});
        end
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        for (i = 0; i < n_words; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_word(mk_tick(7'($urandom)));
            end else if (pick < 75) begin
                b = 8'($urandom);
                if ($urandom_range(4) == 0) b[6:0] = STATE_UNKNOWN;
                send_word(mk_frame(7'($urandom_range(1, 6)), 1'b0, b, 7'($urandom)));
            end else if (pick < 88) begin
                send_word(mk_frame(hb_own_id, 1'b1, 8'($urandom), 7'($urandom)));
            end else begin
                send_word(mk_frame(7'($urandom), 1'($urandom), 8'($urandom),
                                   7'($urandom)));
            end
        end
        settle_block();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // local copy starts at the block's reset values
        hb_own_id   = 7'd1;
        hb_period   = '0;
        hb_count    = '0;
        hb_toggle   = 1'b0;
        hb_prod_cnt = '0;
        foreach (hb_entry[k])     hb_entry[k]     = '0;
        foreach (hb_wdog[k])      hb_wdog[k]      = '0;
        foreach (hb_state_tbl[k]) hb_state_tbl[k] = STATE_UNKNOWN;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_remote_answers();
        test_own_id_extremes();
        test_node_table();
        test_consumer_watchdogs();
        test_entry_corners();
        test_producer_period();
        test_backpressure();
        test_random_traffic(0,  0,  14);
        test_random_traffic(61, 0,  14);
        test_random_traffic(0,  61, 14);
        test_random_traffic(23, 23, 14);

        if (err_count == 0 && pending_hb.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hbm_pkg.sv
sv/hbm_step_alu.sv
sv/hbm_node_table.sv
sv/hbm_sequencer.sv
sv/can_heartbeat_monitor.sv
tb/sv/tb_can_heartbeat_monitor.sv
